### design/dast_pkg.sv
`default_nettype none

package dast_pkg;

  localparam int ID_W         = 48;
  localparam int TAG_W        = 16;
  localparam int ENTRY_W      = TAG_W + ID_W;
  localparam int SLOT_W       = 8;
  localparam int REMOVED_W    = 9;
  localparam int SLOT_COUNT_D = 256;

  localparam logic [TAG_W-1:0] GEN_RESET = 16'd1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_SWEEP  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_MATCHED  = 3'd0,
    ST_ASSIGNED = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_SWEPT    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  bus_number;
    logic [7:0]  port_address;
    logic [7:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  slot;
    logic [15:0] out_vendor;
    logic [15:0] out_product;
    logic [7:0]  out_bus;
    logic [7:0]  out_port;
    logic [8:0]  removed_count;
  } out_word_t;

  // Control broadcast from the scan unit to every cell of the ring.
  typedef struct packed {
    logic shift;
    logic load;
  } ring_ctl_t;

endpackage

`default_nettype wire

### design/dast_cell.sv
`default_nettype none

module dast_cell #(
  parameter int IDX = 0,
  parameter int SW  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dast_pkg::ring_ctl_t           ctl_i,
  input  wire logic [SW-1:0]                 load_idx_i,
  input  wire logic [dast_pkg::ENTRY_W-1:0]  load_data_i,
  input  wire logic [dast_pkg::ENTRY_W-1:0]  shift_data_i,
  output logic      [dast_pkg::ENTRY_W-1:0]  entry_o
);

  logic [dast_pkg::ENTRY_W-1:0] entry_q;
  logic [dast_pkg::ENTRY_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = shift_data_i;
    end else if (ctl_i.load && (load_idx_i == SW'(IDX))) begin
      entry_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### design/dast_scan.sv
`default_nettype none

module dast_scan #(
  parameter int SLOT_COUNT = dast_pkg::SLOT_COUNT_D,
  parameter int SW         = $clog2(SLOT_COUNT)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire dast_pkg::in_word_t            in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output dast_pkg::out_word_t                out_word_o,
  input  wire logic [dast_pkg::ENTRY_W-1:0]  head_i,
  output dast_pkg::ring_ctl_t                ring_o,
  output logic      [dast_pkg::ENTRY_W-1:0]  tail_o,
  output logic      [SW-1:0]                 load_idx_o,
  output logic      [dast_pkg::ENTRY_W-1:0]  load_data_o
);

  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int CMPW = (SW > dast_pkg::SLOT_W) ? SW : dast_pkg::SLOT_W;
  localparam int RW   = (CW > dast_pkg::REMOVED_W) ? CW : dast_pkg::REMOVED_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [1:0]                    cmd_q;
  logic [dast_pkg::ID_W-1:0]     ident_q;
  logic [dast_pkg::SLOT_W-1:0]   idx_q;
  logic [SW-1:0]                 cnt_q;
  logic                          matched_q;
  logic [SW-1:0]                 match_slot_q;
  logic                          have_free_q;
  logic [SW-1:0]                 free_slot_q;
  logic [CW-1:0]                 removed_q;
  logic [dast_pkg::ID_W-1:0]     rd_id_q;
  logic [dast_pkg::TAG_W-1:0]    gen_q;
  logic                          out_valid_q;
  dast_pkg::out_word_t           out_word_q;
  dast_pkg::out_word_t           res;

  logic                          in_fire;
  logic                          done_fire;
  logic [dast_pkg::ID_W-1:0]     in_ident;
  logic [dast_pkg::ID_W-1:0]     head_id;
  logic [dast_pkg::TAG_W-1:0]    head_tag;
  logic                          head_empty;
  logic                          head_hit;
  logic                          head_stale;
  logic                          head_read;
  logic                          do_assign;
  logic [CMPW-1:0]               slot_wide;
  logic [RW-1:0]                 removed_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign done_fire  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_ident   = {in_word_i.vendor_id, in_word_i.product_id,
                       in_word_i.bus_number, in_word_i.port_address};

  assign head_id    = head_i[dast_pkg::ID_W-1:0];
  assign head_tag   = head_i[dast_pkg::ENTRY_W-1:dast_pkg::ID_W];
  assign head_empty = (head_id == '0);
  assign head_hit   = (cmd_q == dast_pkg::CMD_LOOKUP) && !head_empty &&
                      (head_id == ident_q) && !matched_q;
  assign head_stale = (cmd_q == dast_pkg::CMD_SWEEP) && !head_empty && (head_tag != gen_q);
  assign head_read  = (cmd_q == dast_pkg::CMD_READ) && (CMPW'(cnt_q) == CMPW'(idx_q));

  assign do_assign  = (cmd_q == dast_pkg::CMD_LOOKUP) && (ident_q != '0) &&
                      !matched_q && have_free_q;

  // Ring control: rotate while scanning, write the new entry in place at the end.
  always_comb begin
    ring_o.shift = (state_q == S_SCAN);
    ring_o.load  = done_fire && do_assign;
    load_idx_o   = free_slot_q;
    load_data_o  = {gen_q, ident_q};
    tail_o       = head_i;
    if (head_hit) begin
      tail_o = {gen_q, head_id};
    end else if (head_stale) begin
      tail_o = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_word_i.command == dast_pkg::CMD_LOOKUP && in_ident == '0) begin
            state_d = S_DONE;
          end else if (in_word_i.command == dast_pkg::CMD_LOOKUP ||
                       in_word_i.command == dast_pkg::CMD_SWEEP ||
                       in_word_i.command == dast_pkg::CMD_READ) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q == SW'(SLOT_COUNT - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_q       <= dast_pkg::GEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire && cmd_q == dast_pkg::CMD_SWEEP) begin
        gen_q <= gen_q + 1'b1;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= in_word_i.command;
      ident_q     <= in_ident;
      idx_q       <= in_word_i.slot_index;
      cnt_q       <= '0;
      matched_q   <= 1'b0;
      have_free_q <= 1'b0;
      removed_q   <= '0;
      rd_id_q     <= '0;
    end else if (state_q == S_SCAN) begin
      cnt_q <= cnt_q + 1'b1;
      if (cmd_q == dast_pkg::CMD_LOOKUP && head_empty && !have_free_q) begin
        have_free_q <= 1'b1;
        free_slot_q <= cnt_q;
      end
      if (head_hit) begin
        matched_q    <= 1'b1;
        match_slot_q <= cnt_q;
      end
      if (head_stale) begin
        removed_q <= removed_q + 1'b1;
      end
      if (head_read) begin
        rd_id_q <= head_id;
      end
    end
    if (done_fire) begin
      out_word_q <= res;
    end
  end

  always_comb begin
    res          = '0;
    slot_wide    = '0;
    removed_wide = RW'(removed_q);
    case (cmd_q)
      dast_pkg::CMD_LOOKUP: begin
        if (ident_q == '0) begin
          res.status = dast_pkg::ST_EMPTY;
        end else if (matched_q) begin
          res.status = dast_pkg::ST_MATCHED;
          slot_wide  = CMPW'(match_slot_q);
        end else if (have_free_q) begin
          res.status = dast_pkg::ST_ASSIGNED;
          slot_wide  = CMPW'(free_slot_q);
        end else begin
          res.status = dast_pkg::ST_FULL;
        end
        res.slot = slot_wide[dast_pkg::SLOT_W-1:0];
      end
      dast_pkg::CMD_SWEEP: begin
        res.status        = dast_pkg::ST_SWEPT;
        res.removed_count = removed_wide[dast_pkg::REMOVED_W-1:0];
      end
      dast_pkg::CMD_READ: begin
        res.status      = (rd_id_q != '0) ? dast_pkg::ST_MATCHED : dast_pkg::ST_EMPTY;
        res.slot        = idx_q;
        res.out_vendor  = rd_id_q[47:32];
        res.out_product = rd_id_q[31:16];
        res.out_bus     = rd_id_q[15:8];
        res.out_port    = rd_id_q[7:0];
      end
      default: res = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the finish step");

  a_ring_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_o.shift && ring_o.load))
    else $error("ring shift and slot write at once");

  a_gen_only_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_q != $past(gen_q)) |-> $past(state_q == S_DONE && cmd_q == dast_pkg::CMD_SWEEP))
    else $error("generation moved without a sweep");

  a_removed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (RW'(removed_q) <= RW'(SLOT_COUNT)))
    else $error("sweep count exceeds slot count");

endmodule

`default_nettype wire

### design/device_alias_slot_table.sv
// Device alias slot table: maps a 48-bit device identity to a slot number.
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one command word:
// lookup-or-assign, sweep stale entries, or read back one slot. Command code 3
// is taken and dropped without a result. Output channel (out_valid_o /
// out_stall_i / out_word_o) returns one word per other command.
// The entries sit in a ring of SLOT_COUNT cells; every sweep, read or lookup
// of a nonzero identity rotates the ring once past the scan unit, one entry
// per cycle, so the rotation sets the rate; a lookup of the all-zero
// identity skips the scan. A new command is taken only once the previous
// result is registered, so the block handles one command at a time.
// The result register frees the input side: a new command may start while
// an earlier result still waits. If the receiver stalls and a second result
// is ready, the scan unit holds it until the register is taken.
// Reset clears every slot at once (all cells are flip-flops) and sets the
// generation to 1; no clearing pass is needed.
`default_nettype none

module device_alias_slot_table #(
  parameter int SLOT_COUNT = dast_pkg::SLOT_COUNT_D
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dast_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dast_pkg::out_word_t      out_word_o
);

  localparam int SW = $clog2(SLOT_COUNT);

  dast_pkg::ring_ctl_t          ring;
  logic [dast_pkg::ENTRY_W-1:0] tail;
  logic [SW-1:0]                load_idx;
  logic [dast_pkg::ENTRY_W-1:0] load_data;
  logic [dast_pkg::ENTRY_W-1:0] entries [SLOT_COUNT];

  dast_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .SW         (SW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .head_i      (entries[0]),
    .ring_o      (ring),
    .tail_o      (tail),
    .load_idx_o  (load_idx),
    .load_data_o (load_data)
  );

  // Each cell takes its upper neighbor's entry; the last one takes the tail.
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    logic [dast_pkg::ENTRY_W-1:0] shift_in;
    if (g == SLOT_COUNT - 1) begin : g_last
      assign shift_in = tail;
    end else begin : g_mid
      assign shift_in = entries[g+1];
    end
    dast_cell #(
      .IDX (g),
      .SW  (SW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ring),
      .load_idx_i   (load_idx),
      .load_data_i  (load_data),
      .shift_data_i (shift_in),
      .entry_o      (entries[g])
    );
  end

endmodule

`default_nettype wire

### tb/dast_checker.sv
module dast_checker
  import dast_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        errors_o,
  output int        pending_o
);

  logic [ENTRY_W-1:0] slot_entries [SLOT_COUNT_D];
  logic [TAG_W-1:0]   cur_gen;
  out_word_t          expected_q [$];
  int                 mismatches;

  // Apply one command to the table copy; return 1 when it yields a result word.
  function automatic bit apply_command(input in_word_t w, output out_word_t res);
    logic [ID_W-1:0] ident;
    logic [ID_W-1:0] held;
    bit              have_free;
    int              free_idx;
    int              cleared;
    res = '0;
    ident = {w.vendor_id, w.product_id, w.bus_number, w.port_address};
    case (w.command)
      CMD_LOOKUP: begin
        if (ident == '0) begin
          res.status = ST_EMPTY;
          return 1'b1;
        end
        have_free = 1'b0;
        free_idx  = 0;
        for (int i = 0; i < SLOT_COUNT_D; i++) begin
          held = slot_entries[i][ID_W-1:0];
          if (held == '0) begin
            if (!have_free) begin
              have_free = 1'b1;
              free_idx  = i;
            end
          end else if (held == ident) begin
            // refresh the tag of the matching entry
            slot_entries[i] = {cur_gen, ident};
            res.status = ST_MATCHED;
            res.slot   = SLOT_W'(i);
            return 1'b1;
          end
        end
        if (have_free) begin
          slot_entries[free_idx] = {cur_gen, ident};
          res.status = ST_ASSIGNED;
          res.slot   = SLOT_W'(free_idx);
        end else begin
          res.status = ST_FULL;
        end
        return 1'b1;
      end
      CMD_SWEEP: begin
        cleared = 0;
        for (int i = 0; i < SLOT_COUNT_D; i++) begin
          if (slot_entries[i][ID_W-1:0] != '0 &&
              slot_entries[i][ENTRY_W-1:ID_W] != cur_gen) begin
            slot_entries[i] = '0;
            cleared++;
          end
        end
        cur_gen = cur_gen + 1'b1;
        res.status        = ST_SWEPT;
        res.removed_count = REMOVED_W'(cleared);
        return 1'b1;
      end
      CMD_READ: begin
        held = '0;
        if (int'(w.slot_index) < SLOT_COUNT_D) held = slot_entries[w.slot_index][ID_W-1:0];
        res.status = (held != '0) ? ST_MATCHED : ST_EMPTY;
        res.slot   = w.slot_index;
        {res.out_vendor, res.out_product, res.out_bus, res.out_port} = held;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int check_field(input string name, input int unsigned exp_v,
                                     input int unsigned act_v);
    if (exp_v == act_v) return 0;
    $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    out_word_t pred_w;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT_D; i++) slot_entries[i] = '0;
      cur_gen = GEN_RESET;
      expected_q.delete();
      mismatches = 0;
    end else begin
      // compare first: a word taken on this edge cannot belong to a new command
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with no command outstanding: 0x%0h", out_word_i);
          mismatches++;
        end else begin
          exp_w = expected_q.pop_front();
          mismatches += check_field("status", exp_w.status, out_word_i.status);
          mismatches += check_field("slot", exp_w.slot, out_word_i.slot);
          mismatches += check_field("out_vendor", exp_w.out_vendor, out_word_i.out_vendor);
          mismatches += check_field("out_product", exp_w.out_product, out_word_i.out_product);
          mismatches += check_field("out_bus", exp_w.out_bus, out_word_i.out_bus);
          mismatches += check_field("out_port", exp_w.out_port, out_word_i.out_port);
          mismatches += check_field("removed_count", exp_w.removed_count,
                                    out_word_i.removed_count);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (apply_command(in_word_i, pred_w)) expected_q.push_back(pred_w);
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_q.size();
  end

endmodule

### tb/device_alias_slot_table_tb.sv
module device_alias_slot_table_tb;
  import dast_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  int        error_count;
  int        pending_words;
  int        words_sent;
  logic [ID_W-1:0] id_pool [$];

  device_alias_slot_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  dast_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_i (out_word_o),
    .errors_o   (error_count),
    .pending_o  (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [ID_W-1:0] fresh_id();
    return ID_W'({$urandom(), $urandom()});
  endfunction

  function automatic in_word_t make_word(input logic [1:0] cmd, input logic [ID_W-1:0] ident,
                                         input logic [7:0] idx);
    in_word_t w;
    w.command = cmd;
    {w.vendor_id, w.product_id, w.bus_number, w.port_address} = ident;
    w.slot_index = idx;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    // every 64 words, run a burst of 16 back to back
    gap = (words_sent % 64 < 16) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_slot();
    // favor the low slots, where the table fills first
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
  endfunction

  // In fill mode, push mostly new identities and no sweeps so the table runs full.
  task automatic run_mixed(input int count, input bit fill);
    int              done;
    int              pick;
    logic [ID_W-1:0] ident;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_word(make_word(CMD_UNUSED, fresh_id(), 8'($urandom)));
      end else begin
        done++;
        if (!fill && pick < 8) begin
          send_word(make_word(CMD_LOOKUP, '0, 8'($urandom)));
        end else if ((fill && pick < 80) || (!fill && pick < 25) || id_pool.size() == 0) begin
          ident = fresh_id();
          id_pool.push_back(ident);
          send_word(make_word(CMD_LOOKUP, ident, 8'($urandom)));
        end else if ((fill && pick < 90) || (!fill && pick < 50)) begin
          ident = id_pool[$urandom_range(0, id_pool.size() - 1)];
          send_word(make_word(CMD_LOOKUP, ident, 8'($urandom)));
        end else if (!fill && pick < 65) begin
          send_word(make_word(CMD_SWEEP, fresh_id(), 8'($urandom)));
        end else begin
          send_word(make_word(CMD_READ, fresh_id(), pick_slot()));
        end
      end
    end
  endtask

  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      if (taken == 60) hold = 1200;  // long hold-off: fill the block and back up the input
      else if (taken % 50 < 12) hold = 0;
      else hold = $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o || out_stall_i);
      taken++;
    end
  end

  initial begin : stimulus
    words_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(make_word(CMD_LOOKUP, '0, 8'hFF));
    send_word(make_word(CMD_READ, '0, 8'd0));
    send_word(make_word(CMD_LOOKUP, '1, 8'd0));
    send_word(make_word(CMD_LOOKUP, '1, 8'hFF));
    send_word(make_word(CMD_LOOKUP, 48'h0000_0000_0001, 8'h00));
    send_word(make_word(CMD_LOOKUP, 48'hFFFF_0000_0000, 8'hAA));
    send_word(make_word(CMD_LOOKUP, 48'h0000_FFFF_FF00, 8'h55));
    send_word(make_word(CMD_READ, 48'h1234_5678_9ABC, 8'd0));
    send_word(make_word(CMD_READ, '1, 8'd255));
    send_word(make_word(CMD_UNUSED, '1, 8'hFF));
    send_word(make_word(CMD_READ, '0, 8'd1));
    send_word(make_word(CMD_SWEEP, '1, 8'hFF));
    send_word(make_word(CMD_LOOKUP, '1, 8'd0));
    send_word(make_word(CMD_SWEEP, '0, 8'd0));
    send_word(make_word(CMD_READ, '0, 8'd1));
    send_word(make_word(CMD_LOOKUP, 48'h0000_0000_00FF, 8'd0));
    send_word(make_word(CMD_READ, '0, 8'd1));
    send_word(make_word(CMD_SWEEP, '0, 8'd0));
    send_word(make_word(CMD_SWEEP, '0, 8'd0));
    send_word(make_word(CMD_READ, '0, 8'd0));

    run_mixed(150, 1'b0);
    run_mixed(300, 1'b1);
    // first sweep keeps the fresh entries, second one clears the whole table
    send_word(make_word(CMD_SWEEP, fresh_id(), 8'($urandom)));
    send_word(make_word(CMD_SWEEP, fresh_id(), 8'($urandom)));
    run_mixed(80, 1'b0);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    wait (pending_words == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
design/dast_pkg.sv
design/dast_cell.sv
design/dast_scan.sv
design/device_alias_slot_table.sv
tb/dast_checker.sv
tb/device_alias_slot_table_tb.sv
